[src/ble_transport_fragment_engine_macros.svh]
// Assertion macros for the transport fragment engine.
// Used by the top level; empty bodies when SYNTHESIS is defined.
`ifndef BLE_TRANSPORT_FRAGMENT_ENGINE_MACROS_SVH
`define BLE_TRANSPORT_FRAGMENT_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
`define BTFE_ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define BTFE_ASSERT_NORST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define BTFE_ASSERT_IMPL(label, clk, rst, prop)
`define BTFE_ASSERT_NORST(label, clk, prop)
`endif
`endif

[src/btfe_pkg.sv]
// Package for the transport fragment engine: codes, flag bits, phases, sizes.
// No dependencies.
package btfe_pkg;
   localparam int BufferCapacity = 2048;
   localparam logic [7:0] DefaultFrag = 8'd20;

   localparam logic [7:0] FLG_START = 8'h01;
   localparam logic [7:0] FLG_CONT  = 8'h02;
   localparam logic [7:0] FLG_END   = 8'h04;
   localparam logic [7:0] FLG_ACK   = 8'h08;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0, PH_BUSY = 2'd1, PH_DONE = 2'd2, PH_ERR = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      REQ_RX = 3'd0, REQ_TX = 3'd1, REQ_CLR_RX = 3'd2, REQ_CLR_TX = 3'd3,
      REQ_REINIT = 3'd4, REQ_ACK = 3'd5
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_OK = 3'd0, ST_BAD_ACK = 3'd1, ST_BAD_SEQ = 3'd2, ST_BAD_FLAGS = 3'd3,
      ST_TOO_BIG = 3'd4, ST_WRONG_STATE = 3'd5, ST_MISSING = 3'd6, ST_REFUSED = 3'd7
   } status_type;

   localparam logic [1:0] CSR_RX_FRAG = 2'd0;
   localparam logic [1:0] CSR_TX_FRAG = 2'd1;
   localparam logic [1:0] CSR_FIRST_ACK = 2'd2;

   // payload of a result word, highest field first; status sits in the lowest bits of tdata
   typedef struct packed {
      logic [2:0]  hdr_size;
      logic [15:0] hdr_len;
      logic [7:0]  hdr_seq;
      logic [7:0]  hdr_ack;
      logic [7:0]  hdr_flags;
      logic        message_done;
      logic [7:0]  payload_bytes;
      logic [2:0]  payload_offset;
      logic [7:0]  received_ack;
      logic        did_receive_ack;
      logic [2:0]  status;
   } rsp_type;
endpackage

[src/ble_transport_fragment_engine.sv]
// Transport fragment header engine: one request word in, one result word out.
// Result valid the cycle after accept; one word per cycle unless the output stalls.
// A new request is taken while a result waits, as long as the result register is
// free or is emptied in the same cycle.
// Reset (synchronous, active high) restores fragment sizes to 20, role 0, idle phases.
// Depends on btfe_pkg and ble_transport_fragment_engine_macros.svh.
`include "ble_transport_fragment_engine_macros.svh"
module ble_transport_fragment_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: req_type[2:0], header flags byte, rx_byte1..rx_byte4, rx_frag_len,
   //        piggyback ack bit, tx_has_message, tx_msg_len[15:0], zero fill
   input  logic [71:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: status, did_receive_ack, received_ack, payload_offset, payload_bytes,
   //        message_done, hdr_flags, hdr_ack, hdr_seq, hdr_len, hdr_size, zero fill
   output logic [71:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);
   import btfe_pkg::*;

   logic [7:0]  rx_frag_size_ff, tx_frag_size_ff;
   logic        first_ack_ff;
   phase_type   rx_phase_ff, tx_phase_ff;
   logic [7:0]  rx_exp_ff, rx_new_ff, rx_old_ff;
   logic [7:0]  tx_next_ff, tx_new_ff, tx_old_ff;
   logic        awaiting_ff;
   logic [15:0] rx_decl_ff;
   logic [16:0] rx_coll_ff;
   logic [15:0] tx_rem_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff;

   logic [7:0]  rx_frag_size_in, tx_frag_size_in;
   phase_type   rx_phase_in, tx_phase_in;
   logic [7:0]  rx_exp_in, rx_new_in, rx_old_in, tx_next_in, tx_new_in, tx_old_in;
   logic        awaiting_in;
   logic [15:0] rx_decl_in, tx_rem_in;
   logic [16:0] rx_coll_in;
   rsp_type     rsp_in;

   logic        accept;
   logic [2:0]  f_type;
   logic [7:0]  f_flags, f_b1, f_b2, f_b3, f_b4, f_len;
   logic        f_ack, f_msg;
   logic [15:0] f_msglen;

   assign f_type   = req_tdata[2:0];
   assign f_flags  = req_tdata[10:3];
   assign f_b1     = req_tdata[18:11];
   assign f_b2     = req_tdata[26:19];
   assign f_b3     = req_tdata[34:27];
   assign f_b4     = req_tdata[42:35];
   assign f_len    = req_tdata[50:43];
   assign f_ack    = req_tdata[51];
   assign f_msg    = req_tdata[52];
   assign f_msglen = req_tdata[68:53];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   // a register write waits while a request word is taken
   assign csr_ready  = !accept;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b00000, rsp_ff};

   logic in_window;
   always_comb begin
      if (!awaiting_ff) in_window = 1'b0;
      else if (tx_new_ff >= tx_old_ff)
         in_window = (f_b1 <= tx_new_ff) && (f_b1 >= tx_old_ff);
      else in_window = (f_b1 <= tx_new_ff) || (f_b1 >= tx_old_ff);
   end

   always_comb begin
      logic [7:0]  seq_byte, len, lo, hi, cur8, tcur;
      logic [2:0]  cur;
      logic [16:0] pay, kept, coll, trem, tsum;
      logic [7:0]  flags;
      logic        fail;
      logic [2:0]  st;
      rx_frag_size_in = rx_frag_size_ff;
      tx_frag_size_in = tx_frag_size_ff;
      rx_phase_in = rx_phase_ff;  tx_phase_in = tx_phase_ff;
      rx_exp_in = rx_exp_ff;  rx_new_in = rx_new_ff;  rx_old_in = rx_old_ff;
      tx_next_in = tx_next_ff;  tx_new_in = tx_new_ff;  tx_old_in = tx_old_ff;
      awaiting_in = awaiting_ff;
      rx_decl_in = rx_decl_ff;  rx_coll_in = rx_coll_ff;  tx_rem_in = tx_rem_ff;
      rsp_in = '0;
      seq_byte = '0; len = '0; lo = '0; hi = '0; cur8 = '0; tcur = '0;
      cur = 3'd1; pay = '0; kept = '0; coll = '0; trem = '0; tsum = '0;
      flags = '0; fail = 1'b0; st = ST_OK;
      case (f_type)
         REQ_RX: begin
            if (f_flags[3]) begin
               rsp_in.did_receive_ack = 1'b1;
               rsp_in.received_ack = f_b1;
               cur = 3'd2;
               if (!in_window) begin
                  fail = 1'b1; st = ST_BAD_ACK;
               end else if (tx_new_ff == f_b1) begin
                  tx_old_in = f_b1; awaiting_in = 1'b0;
               end else tx_old_in = f_b1 + 8'd1;
            end
            seq_byte = f_flags[3] ? f_b2 : f_b1;
            lo = f_flags[3] ? f_b3 : f_b2;
            hi = f_flags[3] ? f_b4 : f_b3;
            if (!fail) begin
               rx_new_in = seq_byte;
               cur = cur + 3'd1;
               if (seq_byte != rx_exp_ff) begin
                  fail = 1'b1; st = ST_BAD_SEQ;
               end
            end
            if (!fail) begin
               rx_exp_in = rx_exp_ff + 8'd1;
               len = (f_len > rx_frag_size_ff) ? rx_frag_size_ff : f_len;
               if ((f_flags & (FLG_START | FLG_CONT | FLG_END)) == 8'd0) begin
                  rsp_in.payload_offset = cur;
               end else begin
                  case (rx_phase_ff)
                     PH_IDLE: begin
                        if (!f_flags[0]) begin
                           fail = 1'b1; st = ST_BAD_FLAGS;
                        end else begin
                           rx_decl_in = {hi, lo};
                           cur = cur + 3'd2;
                           rx_phase_in = PH_BUSY;
                           cur8 = {5'd0, cur};
                           pay = (len > cur8) ? {9'd0, len - cur8} : 17'd0;
                           coll = pay;
                        end
                     end
                     PH_BUSY: begin
                        if (f_flags[0]) begin
                           fail = 1'b1; st = ST_BAD_FLAGS;
                        end else begin
                           cur8 = {5'd0, cur};
                           pay = (len > cur8) ? {9'd0, len - cur8} : 17'd0;
                           kept = rx_coll_ff;
                           coll = rx_coll_ff + pay;
                           if (coll > 17'(BufferCapacity)) begin
                              fail = 1'b1; st = ST_TOO_BIG;
                           end
                        end
                     end
                     default: begin
                        fail = 1'b1; st = ST_WRONG_STATE;
                     end
                  endcase
                  if (!fail) begin
                     rx_coll_in = coll;
                     if (f_flags[2]) begin
                        if (coll > {1'b0, rx_decl_in}) begin
                           coll = {1'b0, rx_decl_in};
                           pay = (kept >= coll) ? 17'd0 : coll - kept;
                           rx_coll_in = coll;
                        end
                        if (coll != {1'b0, rx_decl_in}) begin
                           fail = 1'b1; st = ST_MISSING;
                        end else begin
                           rx_phase_in = PH_DONE;
                           rsp_in.message_done = 1'b1;
                        end
                     end
                     if (!fail) begin
                        rsp_in.payload_offset = cur;
                        rsp_in.payload_bytes = pay[7:0];
                     end
                  end
               end
            end
            if (fail) rx_phase_in = PH_ERR;
            rsp_in.status = st;
         end
         REQ_TX: begin
            if (f_ack && rx_old_ff == rx_exp_ff) fail = 1'b1;
            else if (tx_phase_ff == PH_IDLE && f_msg) begin
               flags = FLG_START; trem = {1'b0, f_msglen};
            end else if (tx_phase_ff == PH_BUSY && !f_msg) begin
               flags = FLG_CONT; trem = {1'b0, tx_rem_ff};
            end else fail = 1'b1;
            if (fail) rsp_in.status = ST_REFUSED;
            else begin
               if (f_ack) begin
                  flags = flags | FLG_ACK;
                  rsp_in.hdr_ack = rx_new_ff;
                  rx_new_in = rx_exp_ff; rx_old_in = rx_exp_ff;
                  cur = cur + 3'd1;
               end
               rsp_in.hdr_seq = tx_next_ff;
               if (!awaiting_ff) begin
                  awaiting_in = 1'b1; tx_old_in = tx_next_ff;
               end
               tx_new_in = tx_next_ff;
               tx_next_in = tx_next_ff + 8'd1;
               cur = cur + 3'd1;
               if (flags[0]) begin
                  cur = cur + 3'd2;
                  rsp_in.hdr_len = trem[15:0];
               end
               tcur = {5'd0, cur};
               tsum = trem + {14'd0, cur};
               if (tsum <= {9'd0, tx_frag_size_ff}) begin
                  pay = trem; tx_rem_in = '0;
                  flags = flags | FLG_END;
                  tx_phase_in = PH_DONE;
                  rsp_in.message_done = 1'b1;
               end else begin
                  pay = (tx_frag_size_ff > tcur) ? {9'd0, tx_frag_size_ff - tcur} : 17'd0;
                  tx_rem_in = 16'(trem - pay);
                  tx_phase_in = PH_BUSY;
               end
               rsp_in.payload_bytes = pay[7:0];
               rsp_in.hdr_flags = flags;
               rsp_in.hdr_size = cur;
            end
         end
         REQ_CLR_RX: begin
            if (rx_phase_ff == PH_DONE) begin
               rx_phase_in = PH_IDLE; rx_coll_in = '0; rx_decl_in = '0;
            end else rsp_in.status = ST_WRONG_STATE;
         end
         REQ_CLR_TX: begin
            if (tx_phase_ff == PH_DONE) tx_phase_in = PH_IDLE;
            else rsp_in.status = ST_WRONG_STATE;
         end
         REQ_REINIT: begin
            rx_phase_in = PH_IDLE; tx_phase_in = PH_IDLE;
            rx_new_in = '0; rx_old_in = '0; tx_new_in = '0; tx_old_in = '0;
            rx_decl_in = '0; rx_coll_in = '0; tx_rem_in = '0;
            awaiting_in = first_ack_ff;
            tx_next_in = {7'd0, first_ack_ff};
            rx_exp_in = {7'd0, !first_ack_ff};
            rx_frag_size_in = DefaultFrag; tx_frag_size_in = DefaultFrag;
         end
         REQ_ACK: begin
            rsp_in.hdr_flags = FLG_ACK;
            rsp_in.hdr_ack = rx_new_ff;
            rx_new_in = rx_exp_ff; rx_old_in = rx_exp_ff;
            rsp_in.hdr_seq = tx_next_ff;
            if (!awaiting_ff) begin
               awaiting_in = 1'b1; tx_old_in = tx_next_ff;
            end
            tx_new_in = tx_next_ff;
            tx_next_in = tx_next_ff + 8'd1;
            rsp_in.hdr_size = 3'd3;
         end
         default: rsp_in.status = ST_REFUSED;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_frag_size_ff <= DefaultFrag;  tx_frag_size_ff <= DefaultFrag;
         first_ack_ff <= 1'b0;
         rx_phase_ff <= PH_IDLE;  tx_phase_ff <= PH_IDLE;
         rx_exp_ff <= 8'd1;  rx_new_ff <= '0;  rx_old_ff <= '0;
         tx_next_ff <= '0;  tx_new_ff <= '0;  tx_old_ff <= '0;
         awaiting_ff <= 1'b0;
         rx_decl_ff <= '0;  rx_coll_ff <= '0;  tx_rem_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            rx_frag_size_ff <= rx_frag_size_in;  tx_frag_size_ff <= tx_frag_size_in;
            rx_phase_ff <= rx_phase_in;  tx_phase_ff <= tx_phase_in;
            rx_exp_ff <= rx_exp_in;  rx_new_ff <= rx_new_in;  rx_old_ff <= rx_old_in;
            tx_next_ff <= tx_next_in;  tx_new_ff <= tx_new_in;  tx_old_ff <= tx_old_in;
            awaiting_ff <= awaiting_in;
            rx_decl_ff <= rx_decl_in;  rx_coll_ff <= rx_coll_in;  tx_rem_ff <= tx_rem_in;
         end else if (csr_valid) begin
            case (csr_index)
               CSR_RX_FRAG:   rx_frag_size_ff <= csr_data;
               CSR_TX_FRAG:   tx_frag_size_ff <= csr_data;
               CSR_FIRST_ACK: first_ack_ff <= csr_data[0];
               default: ;
            endcase
         end
         if (accept) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) rsp_ff <= rsp_in;
   end

   // a held result word must not change while stalled
   `BTFE_ASSERT_IMPL(a_rsp_hold, clock, reset,
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
   // collected count never exceeds buffer size
   `BTFE_ASSERT_IMPL(a_coll_cap, clock, reset, rx_coll_ff <= 17'(BufferCapacity))
   // every accepted request yields a result in the next cycle
   `BTFE_ASSERT_IMPL(a_accept_rsp, clock, reset, accept |=> rsp_valid_ff)
   `BTFE_ASSERT_NORST(a_reset_idle, clock, reset |=> !rsp_tvalid)
endmodule
